[hw/rtl/dfp_pkg.sv]
package dfp_pkg;

  localparam int VEL_W   = 32;
  localparam int WAVE_W  = 16;
  localparam int NAXIS   = 3;
  localparam int NLANE   = 2 * NAXIS;

  localparam int K2_W    = 2 * WAVE_W;
  localparam int KV_W    = WAVE_W + VEL_W;
  localparam int DOT_W   = KV_W + 2;
  localparam int DOTM_W  = WAVE_W + VEL_W;
  localparam int NUM_W   = DOTM_W + WAVE_W;
  localparam int QW      = VEL_W + 1;
  localparam int DIFF_W  = VEL_W + 4;
  localparam int DIV_LAT = QW + 2;

  typedef logic [NLANE-1:0][VEL_W-1:0] vel_vec_t;

  typedef struct packed {
    vel_vec_t vel;
    logic     zero;
  } side_t;

  typedef struct packed {
    vel_vec_t vel;
    logic     sat;
  } res_t;

endpackage

[hw/rtl/divergence_free_projector.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_wave_x..z, in_vel_x_re..in_vel_z_im
// out     | output    | out_valid / out_stall| out_x_re..out_z_im, out_saturated
//
// one item per cycle sustained while in_stall is low
// latency is set by the 33-step restoring divider, one quotient bit per stage
// synchronous reset clears the valid bits only
// a stalled result waits in the output register, one more item in a skid slot
// in_stall rises only while the skid slot is full
module divergence_free_projector import dfp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WAVE_W-1:0] in_wave_x,
  input  logic signed [WAVE_W-1:0] in_wave_y,
  input  logic signed [WAVE_W-1:0] in_wave_z,
  input  logic signed [VEL_W-1:0]  in_vel_x_re,
  input  logic signed [VEL_W-1:0]  in_vel_x_im,
  input  logic signed [VEL_W-1:0]  in_vel_y_re,
  input  logic signed [VEL_W-1:0]  in_vel_y_im,
  input  logic signed [VEL_W-1:0]  in_vel_z_re,
  input  logic signed [VEL_W-1:0]  in_vel_z_im,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VEL_W-1:0]  out_x_re,
  output logic signed [VEL_W-1:0]  out_x_im,
  output logic signed [VEL_W-1:0]  out_y_re,
  output logic signed [VEL_W-1:0]  out_y_im,
  output logic signed [VEL_W-1:0]  out_z_re,
  output logic signed [VEL_W-1:0]  out_z_im,
  output logic                     out_saturated
);

  logic adv;

  logic                     s1_v_r;
  logic signed [WAVE_W-1:0] s1_k_r [NAXIS];
  vel_vec_t                 s1_vel_r;

  logic                     s2_v_r;
  logic signed [K2_W-1:0]   s2_sq_r [NAXIS];
  logic signed [KV_W-1:0]   s2_kv_r [NLANE];
  logic signed [WAVE_W-1:0] s2_k_r [NAXIS];
  vel_vec_t                 s2_vel_r;

  logic                     s3_v_r;
  logic [K2_W-1:0]          s3_k2_r;
  logic signed [DOT_W-1:0]  s3_dot_r [2];
  logic signed [WAVE_W-1:0] s3_k_r [NAXIS];
  vel_vec_t                 s3_vel_r;

  logic                     s4_v_r;
  logic [K2_W-1:0]          s4_k2_r;
  logic                     s4_zero_r;
  logic [DOTM_W-1:0]        s4_dmag_r [2];
  logic                     s4_dneg_r [2];
  logic [WAVE_W-1:0]        s4_kmag_r [NAXIS];
  logic                     s4_kneg_r [NAXIS];
  vel_vec_t                 s4_vel_r;

  logic                     s5_v_r;
  logic [K2_W-1:0]          s5_k2_r;
  logic                     s5_zero_r;
  logic [NUM_W-1:0]         s5_num_r [NLANE];
  logic                     s5_neg_r [NLANE];
  vel_vec_t                 s5_vel_r;

  logic                     sd_v_r [DIV_LAT];
  side_t                    sd_r   [DIV_LAT];

  logic [QW:0]              quo      [NLANE];
  logic                     quo_neg  [NLANE];

  logic                     res_v_r;
  res_t                     res_r;
  res_t                     res_nxt;
  logic signed [DIFF_W-1:0] diff     [NLANE];
  logic                     lane_ovf [NLANE];

  logic                     out_v_r, out_v_nxt;
  logic                     sk_v_r, sk_v_nxt;
  res_t                     out_r, sk_r;
  logic                     out_take;
  logic                     load_out, load_sk, out_from_sk;

  assign adv      = !sk_v_r;
  assign in_stall = sk_v_r;

  // stage 1: capture
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k_r[0] <= in_wave_x;
      s1_k_r[1] <= in_wave_y;
      s1_k_r[2] <= in_wave_z;
      s1_vel_r  <= {in_vel_z_im, in_vel_z_re, in_vel_y_im, in_vel_y_re,
                    in_vel_x_im, in_vel_x_re};
    end
  end

  // stage 2: products
  for (genvar c = 0; c < NAXIS; c++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_sq_r[c] <= K2_W'(s1_k_r[c]) * K2_W'(s1_k_r[c]);
        s2_k_r[c]  <= s1_k_r[c];
      end
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_kv
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_kv_r[l] <= KV_W'(s1_k_r[l/2]) * KV_W'($signed(s1_vel_r[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_vel_r <= s1_vel_r;
    end
  end

  // stage 3: |k|^2 and dot products
  for (genvar p = 0; p < 2; p++) begin : g_dot
    always_ff @(posedge clk) begin
      if (adv) begin
        s3_dot_r[p] <= {{2{s2_kv_r[p][KV_W-1]}}, s2_kv_r[p]}
                     + {{2{s2_kv_r[2+p][KV_W-1]}}, s2_kv_r[2+p]}
                     + {{2{s2_kv_r[4+p][KV_W-1]}}, s2_kv_r[4+p]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_k2_r  <= $unsigned(s2_sq_r[0]) + $unsigned(s2_sq_r[1]) + $unsigned(s2_sq_r[2]);
      s3_k_r   <= s2_k_r;
      s3_vel_r <= s2_vel_r;
    end
  end

  // stage 4: sign and magnitude
  for (genvar p = 0; p < 2; p++) begin : g_dmag
    logic [DOT_W-1:0] dabs;
    assign dabs = s3_dot_r[p][DOT_W-1] ? $unsigned(-s3_dot_r[p]) : $unsigned(s3_dot_r[p]);
    always_ff @(posedge clk) begin
      if (adv) begin
        s4_dmag_r[p] <= dabs[DOTM_W-1:0];
        s4_dneg_r[p] <= s3_dot_r[p][DOT_W-1];
      end
    end
  end

  for (genvar c = 0; c < NAXIS; c++) begin : g_kmag
    always_ff @(posedge clk) begin
      if (adv) begin
        s4_kmag_r[c] <= s3_k_r[c][WAVE_W-1] ? (~s3_k_r[c] + 1'b1) : s3_k_r[c];
        s4_kneg_r[c] <= s3_k_r[c][WAVE_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_k2_r   <= s3_k2_r;
      s4_zero_r <= (s3_k2_r == '0);
      s4_vel_r  <= s3_vel_r;
    end
  end

  // stage 5: numerators |k.v| * |k_c|
  for (genvar l = 0; l < NLANE; l++) begin : g_num
    always_ff @(posedge clk) begin
      if (adv) begin
        s5_num_r[l] <= NUM_W'(s4_dmag_r[l%2]) * NUM_W'(s4_kmag_r[l/2]);
        s5_neg_r[l] <= s4_dneg_r[l%2] ^ s4_kneg_r[l/2];
      end
    end

    dfp_divider u_div (
      .clk     (clk),
      .en      (adv),
      .num     (s5_num_r[l]),
      .den     (s5_k2_r),
      .neg     (s5_neg_r[l]),
      .quo     (quo[l]),
      .quo_neg (quo_neg[l])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_k2_r   <= s4_k2_r;
      s5_zero_r <= s4_zero_r;
      s5_vel_r  <= s4_vel_r;
    end
  end

  // side data alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= '{vel: s5_vel_r, zero: s5_zero_r};
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // subtract correction and clamp
  for (genvar l = 0; l < NLANE; l++) begin : g_res
    logic signed [DIFF_W-1:0] corr;
    logic signed [DIFF_W-1:0] vext;
    assign corr = quo_neg[l] ? -$signed({{(DIFF_W-QW-1){1'b0}}, quo[l]})
                             : $signed({{(DIFF_W-QW-1){1'b0}}, quo[l]});
    assign vext = $signed({{(DIFF_W-VEL_W){sd_r[DIV_LAT-1].vel[l][VEL_W-1]}},
                           sd_r[DIV_LAT-1].vel[l]});
    assign diff[l] = vext - corr;
    assign lane_ovf[l] = (diff[l][DIFF_W-1:VEL_W-1] != '0)
                      && (diff[l][DIFF_W-1:VEL_W-1] != '1);
  end

  always_comb begin
    res_nxt.vel = sd_r[DIV_LAT-1].vel;
    res_nxt.sat = 1'b0;
    if (!sd_r[DIV_LAT-1].zero) begin
      for (int l = 0; l < NLANE; l++) begin
        if (lane_ovf[l]) begin
          res_nxt.vel[l] = {diff[l][DIFF_W-1], {(VEL_W-1){!diff[l][DIFF_W-1]}}};
          res_nxt.sat    = 1'b1;
        end else begin
          res_nxt.vel[l] = diff[l][VEL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      res_v_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        sd_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      sd_v_r[0] <= s5_v_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_v_r[i] <= sd_v_r[i-1];
      end
      res_v_r <= sd_v_r[DIV_LAT-1];
    end
  end

  // output register and skid slot
  assign out_take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt   = out_v_r;
    sk_v_nxt    = sk_v_r;
    load_out    = 1'b0;
    load_sk     = 1'b0;
    out_from_sk = 1'b0;
    if (sk_v_r) begin
      if (out_take) begin
        out_from_sk = 1'b1;
        out_v_nxt   = 1'b1;
        sk_v_nxt    = 1'b0;
      end
    end else if (res_v_r) begin
      if (!out_v_r || out_take) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_sk  = 1'b1;
        sk_v_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_sk) begin
      out_r <= sk_r;
    end else if (load_out) begin
      out_r <= res_r;
    end
    if (load_sk) begin
      sk_r <= res_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_x_re      = out_r.vel[0];
  assign out_x_im      = out_r.vel[1];
  assign out_y_re      = out_r.vel[2];
  assign out_y_im      = out_r.vel[3];
  assign out_z_re      = out_r.vel[4];
  assign out_z_im      = out_r.vel[5];
  assign out_saturated = out_r.sat;

endmodule

[hw/rtl/dfp_divider.sv]
module dfp_divider import dfp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [K2_W-1:0]  den,
  input  logic             neg,
  output logic [QW:0]      quo,
  output logic             quo_neg
);

  logic [K2_W-1:0] rem_r [QW+1];
  logic [QW-1:0]   quo_r [QW+1];
  logic [QW-1:0]   low_r [QW+1];
  logic [K2_W-1:0] den_r [QW+1];
  logic            neg_r [QW+1];
  logic [QW:0]     quo_o_r;
  logic            neg_o_r;
  logic            round_up;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= K2_W'(num[NUM_W-1:QW]);
      low_r[0] <= num[QW-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [K2_W:0] trial;
    logic [K2_W:0] diff;
    logic          take;

    assign trial = {rem_r[i], low_r[i][QW-1-i]};
    assign diff  = trial - {1'b0, den_r[i]};
    assign take  = (trial >= {1'b0, den_r[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= take ? diff[K2_W-1:0] : trial[K2_W-1:0];
        quo_r[i+1] <= {quo_r[i][QW-2:0], take};
        low_r[i+1] <= low_r[i];
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // round to nearest, ties away from zero
  assign round_up = ({rem_r[QW], 1'b0} >= {1'b0, den_r[QW]});

  always_ff @(posedge clk) begin
    if (en) begin
      quo_o_r <= {1'b0, quo_r[QW]} + {{QW{1'b0}}, round_up};
      neg_o_r <= neg_r[QW];
    end
  end

  assign quo     = quo_o_r;
  assign quo_neg = neg_o_r;

endmodule

[verif/divergence_free_projector_test.sv]
`timescale 1ns / 100ps

import dfp_pkg::*;

typedef struct packed {
  logic [NAXIS-1:0][WAVE_W-1:0] wave;
  vel_vec_t                     vel;
} mode_t;

class mode_ledger;
  res_t        projected_q[$];
  int unsigned failures;
  string       lane_name[NLANE] = '{"out_x_re", "out_x_im", "out_y_re",
                                    "out_y_im", "out_z_re", "out_z_im"};

  // velocity minus its component along the wavevector, clamped per lane
  function res_t project(mode_t m);
    logic signed [95:0] k[NAXIS];
    logic signed [95:0] v[NLANE];
    logic signed [95:0] k2, dot, num, mag, q, diff, top, bottom;
    logic               neg;
    res_t               r;
    top = (96'sd1 <<< (VEL_W - 1)) - 96'sd1;
    bottom = -top - 96'sd1;
    r.sat = 1'b0;
    for (int c = 0; c < NAXIS; c++) k[c] = $signed(m.wave[c]);
    for (int i = 0; i < NLANE; i++) v[i] = $signed(m.vel[i]);
    k2 = k[0] * k[0] + k[1] * k[1] + k[2] * k[2];
    if (k2 == 0) begin
      r.vel = m.vel;
      return r;
    end
    for (int p = 0; p < 2; p++) begin
      dot = k[0] * v[p] + k[1] * v[2 + p] + k[2] * v[4 + p];
      for (int c = 0; c < NAXIS; c++) begin
        num = dot * k[c];
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / k2;
        // round half away from zero
        if (((mag % k2) <<< 1) >= k2) q = q + 96'sd1;
        diff = v[2 * c + p] - (neg ? -q : q);
        if (diff > top) begin
          diff = top;
          r.sat = 1'b1;
        end
        if (diff < bottom) begin
          diff = bottom;
          r.sat = 1'b1;
        end
        r.vel[2 * c + p] = diff[VEL_W-1:0];
      end
    end
    return r;
  endfunction

  function void note_mode(mode_t m);
    projected_q.push_back(project(m));
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (projected_q.size() == 0) begin
      $error("result with no item outstanding");
      failures++;
      return;
    end
    want = projected_q.pop_front();
    for (int i = 0; i < NLANE; i++) begin
      if (got.vel[i] !== want.vel[i]) begin
        $error("%s: expected %0d, actual %0d", lane_name[i],
               $signed(want.vel[i]), $signed(got.vel[i]));
        failures++;
      end
    end
    if (got.sat !== want.sat) begin
      $error("out_saturated: expected %0d, actual %0d", want.sat, got.sat);
      failures++;
    end
  endfunction
endclass

module divergence_free_projector_test;

  localparam int VTOP = 32'sh7fff_ffff;
  localparam int VBOT = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [WAVE_W-1:0] in_wave_x, in_wave_y, in_wave_z;
  logic signed [VEL_W-1:0]  in_vel_x_re, in_vel_x_im, in_vel_y_re;
  logic signed [VEL_W-1:0]  in_vel_y_im, in_vel_z_re, in_vel_z_im;
  logic out_valid;
  logic out_stall;
  logic signed [VEL_W-1:0]  out_x_re, out_x_im, out_y_re, out_y_im, out_z_re, out_z_im;
  logic out_saturated;

  mode_ledger ledger;
  bit         idling;
  bit         hold_req;

  divergence_free_projector dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_wave_x    (in_wave_x),
    .in_wave_y    (in_wave_y),
    .in_wave_z    (in_wave_z),
    .in_vel_x_re  (in_vel_x_re),
    .in_vel_x_im  (in_vel_x_im),
    .in_vel_y_re  (in_vel_y_re),
    .in_vel_y_im  (in_vel_y_im),
    .in_vel_z_re  (in_vel_z_re),
    .in_vel_z_im  (in_vel_z_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x_re     (out_x_re),
    .out_x_im     (out_x_im),
    .out_y_re     (out_y_re),
    .out_y_im     (out_y_im),
    .out_z_re     (out_z_re),
    .out_z_im     (out_z_im),
    .out_saturated(out_saturated)
  );

  always #6 clk = ~clk;

  function automatic mode_t mk(input int kx, ky, kz, xr, xi, yr, yi, zr, zi);
    mode_t m;
    m.wave[0] = WAVE_W'(kx);
    m.wave[1] = WAVE_W'(ky);
    m.wave[2] = WAVE_W'(kz);
    m.vel[0] = VEL_W'(xr);
    m.vel[1] = VEL_W'(xi);
    m.vel[2] = VEL_W'(yr);
    m.vel[3] = VEL_W'(yi);
    m.vel[4] = VEL_W'(zr);
    m.vel[5] = VEL_W'(zi);
    return m;
  endfunction

  function automatic logic [VEL_W-1:0] corner_vel();
    case ($urandom_range(0, 4))
      0: return {1'b1, {(VEL_W-1){1'b0}}};
      1: return {1'b0, {(VEL_W-1){1'b1}}};
      2: return '0;
      3: return VEL_W'(1);
      default: return '1;
    endcase
  endfunction

  function automatic logic [WAVE_W-1:0] corner_wave();
    case ($urandom_range(0, 4))
      0: return {1'b1, {(WAVE_W-1){1'b0}}};
      1: return {1'b0, {(WAVE_W-1){1'b1}}};
      2: return '0;
      3: return WAVE_W'(1);
      default: return '1;
    endcase
  endfunction

  function automatic mode_t random_mode();
    mode_t m;
    int    kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < NLANE; i++) m.vel[i] = $urandom;
    for (int c = 0; c < NAXIS; c++) m.wave[c] = WAVE_W'($urandom);
    if (kind >= 10 && kind <= 12) begin
      for (int c = 0; c < NAXIS; c++) m.wave[c] = WAVE_W'($urandom_range(0, 8) - 4);
    end else if (kind <= 14 && kind >= 13) begin
      m.wave = '0;
    end else if (kind >= 15 && kind <= 16) begin
      m.wave[$urandom_range(0, 2)] = '0;
      if ($urandom_range(0, 1)) m.wave[$urandom_range(0, 2)] = '0;
    end else if (kind >= 17) begin
      for (int i = 0; i < NLANE; i++) m.vel[i] = corner_vel();
      for (int c = 0; c < NAXIS; c++) begin
        if (kind == 19) m.wave[c] = WAVE_W'($urandom_range(0, 2) - 1);
        else m.wave[c] = corner_wave();
      end
    end
    return m;
  endfunction

  // entered and left at a falling edge
  task automatic offer(input mode_t m);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_wave_x <= m.wave[0];
    in_wave_y <= m.wave[1];
    in_wave_z <= m.wave[2];
    in_vel_x_re <= m.vel[0];
    in_vel_x_im <= m.vel[1];
    in_vel_y_re <= m.vel[2];
    in_vel_y_im <= m.vel[3];
    in_vel_z_re <= m.vel[4];
    in_vel_z_im <= m.vel[5];
    do @(posedge clk); while (in_stall);
    ledger.note_mode(m);
    @(negedge clk);
  endtask

  // receiver side
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (249) @(negedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.vel[0] = out_x_re;
      got.vel[1] = out_x_im;
      got.vel[2] = out_y_re;
      got.vel[3] = out_y_im;
      got.vel[4] = out_z_re;
      got.vel[5] = out_z_im;
      got.sat = out_saturated;
      ledger.check_result(got);
    end
  end

  initial begin
    #5_000_000;
    $display("divergence_free_projector regression: fail");
    $finish;
  end

  initial begin
    mode_t directed[$];
    ledger = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_wave_x <= '0;
    in_wave_y <= '0;
    in_wave_z <= '0;
    in_vel_x_re <= '0;
    in_vel_x_im <= '0;
    in_vel_y_re <= '0;
    in_vel_y_im <= '0;
    in_vel_z_re <= '0;
    in_vel_z_im <= '0;
    idling = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero wavevector passes through
    directed.push_back(mk(0, 0, 0, VTOP, VBOT, VBOT, VTOP, 0, -1));
    directed.push_back(mk(0, 0, 0, 1, -1, 0, 0, VTOP, VBOT));
    // single axis
    directed.push_back(mk(256, 0, 0, 12345, -678, 9, 10, 11, 12));
    directed.push_back(mk(0, -256, 0, -5, 77, 123456, -654321, 3, 4));
    directed.push_back(mk(0, 0, 32767, 40, 50, 60, 70, VTOP, VBOT));
    directed.push_back(mk(-32768, 0, 0, VBOT, VTOP, 1, 2, 3, 4));
    directed.push_back(mk(1, 0, 0, 7, -7, 8, -8, 9, -9));
    // rounding, mostly ties
    directed.push_back(mk(1, 1, 0, 1, -1, 0, 0, 5, -5));
    directed.push_back(mk(1, 1, 0, 0, 0, 1, -1, 0, 0));
    directed.push_back(mk(-1, -1, -1, 1, 2, 0, -1, 0, 0));
    // clamping
    directed.push_back(mk(1, 1, 0, VTOP, VBOT, VBOT, VTOP, 0, 0));
    directed.push_back(mk(1, 1, 1, VBOT, VTOP, VTOP, VBOT, VTOP, VBOT));
    directed.push_back(mk(1, -1, 0, VTOP, VTOP, VBOT, VBOT, 0, 0));
    // largest wavenumbers, then one mixed mode
    directed.push_back(mk(32767, 32767, 32767, VTOP, VTOP, VTOP, VTOP, VTOP, VTOP));
    directed.push_back(mk(-32768, -32768, -32768, VBOT, VBOT, VBOT, VBOT, VBOT, VBOT));
    directed.push_back(mk(-32768, 32767, -32768, VTOP, VBOT, VBOT, VTOP, VTOP, VBOT));
    directed.push_back(mk(3, -7, 2, 100000, -200000, 300000, -400000, 500000, -600000));
    foreach (directed[i]) offer(directed[i]);

    for (int n = 0; n < 1200; n++) begin
      if (n % 100 == 0) idling = (n < 1000) && ($urandom_range(0, 3) != 0);
      if (n == 400) begin
        // long receiver hold with the sender pushing back to back
        idling = 1'b0;
        hold_req = 1'b1;
      end
      offer(random_mode());
    end
    in_valid <= 1'b0;

    while (ledger.projected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (ledger.failures == 0 && ledger.projected_q.size() == 0) begin
      $display("divergence_free_projector regression: pass");
    end else begin
      $display("divergence_free_projector regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_divider.sv
hw/rtl/divergence_free_projector.sv
verif/divergence_free_projector_test.sv
